// ===== rtl/mcit_pkg.sv =====
// ----------------------------------------------------------------------------
// mcit_pkg
// Shared constants, codes and types of the multi-channel interval timer.
// ----------------------------------------------------------------------------
package mcit_pkg;

  // Table geometry
  localparam int CHANNELS = 16;
  localparam int ACTIVE   = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int OP_W     = 3;
  localparam int CHAN_W   = 4;
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 16;
  localparam int REM_W    = 33;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = 2 * VAL_W;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd10;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_SET_IVL = 3'd5,
    OP_READ    = 3'd6,
    OP_ACK     = 3'd7
  } opcode_t;

  // Reply status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_INUSE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd2;

  // Result kinds
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  // One result transaction
  typedef struct packed {
    logic                    kind;
    logic [STAT_W-1:0]       status;
    logic [CHAN_W-1:0]       chan;
    logic signed [REM_W-1:0] remaining;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/mcit_ram.sv =====
// ----------------------------------------------------------------------------
// mcit_ram
// Single-clock RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mcit_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mcit_out_reg.sv =====
// ----------------------------------------------------------------------------
// mcit_out_reg
// Output register of the result channel; registers the result, though can_push
// still follows the downstream ready.
// ----------------------------------------------------------------------------
module mcit_out_reg
  import mcit_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // Slot is free when empty or drained this cycle
  assign can_push = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (push && can_push) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload on push
  always_ff @(posedge clk) begin
    if (push && can_push) begin
      res_r <= push_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/mcit_seq.sv =====
// ----------------------------------------------------------------------------
// mcit_seq
// Operation sequencer: holds the allocated and running flags, reads and
// writes the period/elapsed table, scans channels on a tick.
// ----------------------------------------------------------------------------
module mcit_seq
  import mcit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CHAN_W-1:0]  in_chan,
  input  logic               in_pick,
  input  logic [VAL_W-1:0]   in_ival,
  // Configuration
  input  logic [STEP_W-1:0]  tick_step,
  // Table port
  output logic               tbl_we,
  output logic [CH_W-1:0]    tbl_waddr,
  output logic [ENTRY_W-1:0] tbl_wdata,
  output logic [CH_W-1:0]    tbl_raddr,
  input  logic [ENTRY_W-1:0] tbl_rdata,
  // Result push
  output logic               push,
  output res_t               push_res,
  input  logic               can_push
);

  typedef enum logic [1:0] {S_IDLE, S_OP, S_TICK, S_FLUSH} state_t;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(ACTIVE - 1);

  state_t              state_r, state_nxt;
  logic [CH_W-1:0]     cnt_r, cnt_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic [CH_W-1:0]     held_ch_r, held_ch_nxt;
  opcode_t             op_r, op_nxt;
  logic [CHAN_W-1:0]   ch_r, ch_nxt;
  logic                pick_r, pick_nxt;
  logic [VAL_W-1:0]    ival_r, ival_nxt;
  logic [CHANNELS-1:0] alloc_r, alloc_nxt;
  logic [CHANNELS-1:0] run_r, run_nxt;

  logic [VAL_W-1:0]    rd_p;
  logic [VAL_W-1:0]    rd_e;
  logic [VAL_W:0]      sum;
  logic [VAL_W-1:0]    e_new;
  logic                act;
  logic                fire;
  logic                ch_ok;
  logic [CH_W-1:0]     ch_idx;
  logic                ch_valid;
  logic                free_found;
  logic [CH_W-1:0]     free_idx;
  logic [CH_W-1:0]     slot;
  logic                alloc_ok;

  assign rd_p = tbl_rdata[ENTRY_W-1:VAL_W];
  assign rd_e = tbl_rdata[VAL_W-1:0];

  // Channel decode of the held operation
  assign ch_ok    = (32'(ch_r) < ACTIVE);
  assign ch_idx   = CH_W'(ch_r);
  assign ch_valid = ch_ok && alloc_r[ch_idx];

  // Lowest free channel
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ACTIVE - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  // Tick update of the scanned channel, saturating at full scale
  assign act   = alloc_r[cnt_r] && run_r[cnt_r] && (rd_e < rd_p);
  assign sum   = {1'b0, rd_e} + {{(VAL_W + 1 - STEP_W){1'b0}}, tick_step};
  assign e_new = sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
  assign fire  = act && (e_new >= rd_p);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    held_valid_nxt = held_valid_r;
    held_ch_nxt    = held_ch_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    pick_nxt       = pick_r;
    ival_nxt       = ival_r;
    alloc_nxt      = alloc_r;
    run_nxt        = run_r;
    tbl_we         = 1'b0;
    tbl_waddr      = cnt_r;
    tbl_wdata      = {rd_p, e_new};
    tbl_raddr      = cnt_r;
    push           = 1'b0;
    push_res       = '0;
    slot           = ch_idx;
    alloc_ok       = 1'b0;

    unique case (state_r)
      // Take a transaction and start its table read
      S_IDLE: begin
        if (in_op == OP_TICK) begin
          tbl_raddr = '0;
        end else begin
          tbl_raddr = CH_W'(in_chan);
        end
        if (in_valid) begin
          op_nxt         = opcode_t'(in_op);
          ch_nxt         = in_chan;
          pick_nxt       = in_pick;
          ival_nxt       = in_ival;
          cnt_nxt        = '0;
          held_valid_nxt = 1'b0;
          state_nxt      = (in_op == OP_TICK) ? S_TICK : S_OP;
        end
      end

      // Single operation: read data is valid, reply and write back
      S_OP: begin
        tbl_raddr       = ch_idx;
        push            = 1'b1;
        push_res.kind   = KIND_REPLY;
        push_res.last   = 1'b1;
        push_res.status = ST_INUSE;
        if (op_r == OP_ALLOC) begin
          if (pick_r) begin
            slot            = free_idx;
            alloc_ok        = free_found;
            push_res.status = free_found ? ST_OK : ST_NOFREE;
          end else begin
            alloc_ok        = ch_ok && !alloc_r[ch_idx];
            push_res.status = alloc_ok ? ST_OK : ST_INUSE;
          end
          if (alloc_ok) begin
            push_res.chan = CHAN_W'(slot);
          end
        end else if (ch_valid) begin
          push_res.status = ST_OK;
          if (op_r == OP_READ) begin
            push_res.remaining = REM_W'({1'b0, rd_p}) - REM_W'({1'b0, rd_e});
          end
        end
        if (can_push) begin
          state_nxt = S_IDLE;
          tbl_waddr = slot;
          if (op_r == OP_ALLOC) begin
            if (alloc_ok) begin
              alloc_nxt[slot] = 1'b1;
              run_nxt[slot]   = 1'b0;
              tbl_we          = 1'b1;
              tbl_wdata       = {ival_r, {VAL_W{1'b0}}};
            end
          end else if (ch_valid) begin
            case (op_r)
              OP_RELEASE: begin
                alloc_nxt[ch_idx] = 1'b0;
                run_nxt[ch_idx]   = 1'b0;
              end
              OP_ENABLE:  run_nxt[ch_idx] = 1'b1;
              OP_DISABLE: run_nxt[ch_idx] = 1'b0;
              OP_SET_IVL: begin
                tbl_we    = 1'b1;
                tbl_wdata = {ival_r, rd_e};
              end
              OP_ACK: begin
                tbl_we    = 1'b1;
                tbl_wdata = {rd_p, {VAL_W{1'b0}}};
              end
              default: ;
            endcase
          end
        end
      end

      // Scan one channel per cycle unless a fire push stalls; hold the latest fire until the next one
      S_TICK: begin
        tbl_raddr = cnt_r + CH_W'(1);
        if (fire && held_valid_r) begin
          push          = 1'b1;
          push_res.kind = KIND_FIRE;
          push_res.chan = CHAN_W'(held_ch_r);
        end
        if (fire && held_valid_r && !can_push) begin
          // Stall: re-read the same entry
          tbl_raddr = cnt_r;
        end else begin
          tbl_we = act;
          if (fire) begin
            held_valid_nxt = 1'b1;
            held_ch_nxt    = cnt_r;
          end
          cnt_nxt = cnt_r + CH_W'(1);
          if (cnt_r == LAST_CH) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      // Emit the final fire with last set
      S_FLUSH: begin
        if (held_valid_r) begin
          push          = 1'b1;
          push_res.kind = KIND_FIRE;
          push_res.chan = CHAN_W'(held_ch_r);
          push_res.last = 1'b1;
          if (can_push) begin
            held_valid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      held_valid_r <= 1'b0;
      alloc_r      <= '0;
      run_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      held_valid_r <= held_valid_nxt;
      alloc_r      <= alloc_nxt;
      run_r        <= run_nxt;
    end
  end

  // Operation payload and held channel
  always_ff @(posedge clk) begin
    held_ch_r <= held_ch_nxt;
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    pick_r    <= pick_nxt;
    ival_r    <= ival_nxt;
  end

endmodule

// ===== rtl/multi_channel_interval_timer.sv =====
// ----------------------------------------------------------------------------
// multi_channel_interval_timer
// Table of interval timer channels driven by a common tick.
// ----------------------------------------------------------------------------
// Each channel's period and elapsed count live in one synchronous RAM entry;
// allocated and running flags sit in flip-flops cleared by reset. The block
// works on one transaction at a time. A non-tick operation reads the table
// when accepted, then replies and writes back once the output can take the
// reply. A tick scans every channel through the single RAM read port, one
// channel per cycle unless a fire result stalls on the output; each fire is
// a result transaction and the last one carries tlast. A tick with no fires
// produces nothing. No clearing pass is needed after reset: an entry is read
// only for allocated channels, and allocate writes it first.
module multi_channel_interval_timer
  import mcit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: tick_step
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  // Operation input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // channel[3:0], auto_pick[4], interval_value[36:5], zero
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status[1:0], result_channel[5:2], remaining[38:6], zero
  output logic        out_tuser,  // kind[0]
  output logic        out_tlast
);

  logic [STEP_W-1:0]  tick_step_r;
  logic               tbl_we;
  logic [CH_W-1:0]    tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [CH_W-1:0]    tbl_raddr;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               push;
  logic               can_push;
  res_t               push_res;
  res_t               out_res;

  // Tick step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= TICK_STEP_RESET;
    end else if (cfg_wen) begin
      tick_step_r <= cfg_wdata;
    end
  end

  mcit_ram #(
    .DEPTH  (CHANNELS),
    .ADDR_W (CH_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  mcit_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_chan   (in_tdata[3:0]),
    .in_pick   (in_tdata[4]),
    .in_ival   (in_tdata[36:5]),
    .tick_step (tick_step_r),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata),
    .push      (push),
    .push_res  (push_res),
    .can_push  (can_push)
  );

  mcit_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result
  assign out_tdata = {1'b0, out_res.remaining, out_res.chan, out_res.status};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // A reply always closes its transaction
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_REPLY) |-> out_tlast)
    else $error("reply without last");

  // A fire result carries ok status and no remaining count
  a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_FIRE) |->
      (out_tdata[1:0] == ST_OK) && (out_tdata[38:6] == '0))
    else $error("fire result with stray fields");

  // One transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // Failed replies report no channel
  a_fail_no_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_REPLY) && (out_tdata[1:0] != ST_OK) |->
      (out_tdata[5:2] == '0) && (out_tdata[38:6] == '0))
    else $error("failed reply with channel or remaining set");

endmodule
